>>> rtl/wjmc_pkg.sv
package wjmc_pkg;

  localparam int HEIGHT_IN_BITS   = 16;
  localparam int COST_BITS        = 32;
  localparam int LIMIT_BITS       = 5;

  localparam int MAX_JUMP_DEF     = 16;
  localparam int HEIGHT_BITS_DEF  = 16;

  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(1);
  localparam logic [COST_BITS-1:0]  COST_MAX    = {COST_BITS{1'b1}};

endpackage

>>> rtl/wjmc_window_mem.sv
module wjmc_window_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 48,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/windowed_jump_min_cost_dp.sv
// A stone that starts a sequence gets cost zero with no window reads; else
//   span entries are read, span = min(stones in window, effective jump limit).
// in_stall holds off a new request until the current result is issued; the
//   window memory's single read port and one add/compare unit take reads in turn.
// Reset: synchronous, active low; jump limit returns to 1 and the window count
//   to zero. Window memory contents are not cleared; the fill count masks them.
module windowed_jump_min_cost_dp #(
  parameter int MAX_JUMP    = wjmc_pkg::MAX_JUMP_DEF,
  parameter int HEIGHT_BITS = wjmc_pkg::HEIGHT_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [wjmc_pkg::LIMIT_BITS-1:0]      cfg_wr_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [wjmc_pkg::HEIGHT_IN_BITS-1:0]  in_height,
  input  logic                                 in_first_stone,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [wjmc_pkg::COST_BITS-1:0]       out_reach_cost
);
  import wjmc_pkg::*;

  localparam int HW   = (HEIGHT_BITS < HEIGHT_IN_BITS) ? HEIGHT_BITS : HEIGHT_IN_BITS;
  localparam int AW   = (MAX_JUMP > 1) ? $clog2(MAX_JUMP) : 1;
  localparam int SW   = $clog2(MAX_JUMP + 1);
  localparam int MW   = HW + COST_BITS;
  localparam int CW   = COST_BITS + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_FINISH
  } state_t;

  state_t              state_r, state_nxt;
  logic [LIMIT_BITS-1:0] limit_r, limit_nxt;
  logic [HW-1:0]       h_r, h_nxt;
  logic [SW-1:0]       span_r, span_nxt;
  logic [SW-1:0]       issue_cnt_r, issue_cnt_nxt;
  logic [SW-1:0]       seen_r, seen_nxt;
  logic [AW-1:0]       raddr_r, raddr_nxt;
  logic [AW-1:0]       wptr_r, wptr_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic                cand_vld_r, cand_vld_nxt;
  logic [CW-1:0]       cand_r, cand_nxt;
  logic [CW-1:0]       best_r, best_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [COST_BITS-1:0] out_cost_r, out_cost_nxt;

  logic                mem_we;
  logic [MW-1:0]       mem_wdata;
  logic [MW-1:0]       mem_rdata;
  logic [HW-1:0]       rd_height;
  logic [COST_BITS-1:0] rd_cost;
  logic [HW-1:0]       hdiff;
  logic [SW-1:0]       lim_eff;
  logic [SW-1:0]       seen_eff;
  logic                in_acc;
  logic                issue;
  logic                out_free;

  function automatic logic [AW-1:0] addr_dec(input logic [AW-1:0] a);
    if (a == '0) begin
      return AW'(MAX_JUMP - 1);
    end
    return a - AW'(1);
  endfunction

  function automatic logic [AW-1:0] addr_inc(input logic [AW-1:0] a);
    if (a == AW'(MAX_JUMP - 1)) begin
      return '0;
    end
    return a + AW'(1);
  endfunction

  wjmc_window_mem #(
    .DEPTH (MAX_JUMP),
    .WIDTH (MW),
    .AW    (AW)
  ) u_window (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (wptr_r),
    .wr_data (mem_wdata),
    .rd_addr (raddr_r),
    .rd_data (mem_rdata)
  );

  assign rd_height = mem_rdata[MW-1:COST_BITS];
  assign rd_cost   = mem_rdata[COST_BITS-1:0];
  assign hdiff     = (rd_height > h_r) ? (rd_height - h_r) : (h_r - rd_height);

  always_comb begin
    if (limit_r == '0) begin
      lim_eff = SW'(1);
    end else if (32'(limit_r) > 32'(MAX_JUMP)) begin
      lim_eff = SW'(MAX_JUMP);
    end else begin
      lim_eff = SW'(limit_r);
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign seen_eff  = in_first_stone ? '0 : seen_r;
  assign issue     = (state_r == ST_READ) && (issue_cnt_r != span_r);
  assign out_free  = !out_valid_r || !out_stall;
  assign mem_we    = (state_r == ST_FINISH) && out_free;
  assign mem_wdata = {h_r, best_r[COST_BITS-1:0]};

  always_comb begin
    state_nxt     = state_r;
    limit_nxt     = cfg_wr_en ? cfg_wr_data : limit_r;
    h_nxt         = h_r;
    span_nxt      = span_r;
    issue_cnt_nxt = issue_cnt_r;
    seen_nxt      = seen_r;
    raddr_nxt     = raddr_r;
    wptr_nxt      = wptr_r;
    rd_vld_nxt    = issue;
    cand_vld_nxt  = rd_vld_r;
    cand_nxt      = cand_r;
    best_nxt      = best_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_cost_nxt  = out_cost_r;

    // stage 1: candidate cost from the entry read last cycle
    if (rd_vld_r) begin
      cand_nxt = CW'(rd_cost) + CW'(hdiff);
    end
    // stage 2: keep the smaller
    if (cand_vld_r && (cand_r < best_r)) begin
      best_nxt = cand_r;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          h_nxt         = in_height[HW-1:0];
          issue_cnt_nxt = '0;
          raddr_nxt     = addr_dec(wptr_r);
          if (seen_eff == '0) begin
            seen_nxt  = '0;
            span_nxt  = '0;
            best_nxt  = '0;
            state_nxt = ST_FINISH;
          end else begin
            span_nxt  = (seen_eff < lim_eff) ? seen_eff : lim_eff;
            best_nxt  = CW'(COST_MAX);
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        if (issue) begin
          issue_cnt_nxt = issue_cnt_r + SW'(1);
          raddr_nxt     = addr_dec(raddr_r);
        end else if (!rd_vld_r && !cand_vld_r) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold until the output register is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_cost_nxt  = best_r[COST_BITS-1:0];
          wptr_nxt      = addr_inc(wptr_r);
          if (32'(seen_r) < 32'(MAX_JUMP)) begin
            seen_nxt = seen_r + SW'(1);
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      limit_r     <= LIMIT_RESET;
      seen_r      <= '0;
      wptr_r      <= '0;
      issue_cnt_r <= '0;
      span_r      <= '0;
      rd_vld_r    <= 1'b0;
      cand_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      limit_r     <= limit_nxt;
      seen_r      <= seen_nxt;
      wptr_r      <= wptr_nxt;
      issue_cnt_r <= issue_cnt_nxt;
      span_r      <= span_nxt;
      rd_vld_r    <= rd_vld_nxt;
      cand_vld_r  <= cand_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    h_r        <= h_nxt;
    raddr_r    <= raddr_nxt;
    cand_r     <= cand_nxt;
    best_r     <= best_nxt;
    out_cost_r <= out_cost_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_reach_cost = out_cost_r;

`ifndef SYNTHESIS
  a_seen_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    32'(seen_r) <= 32'(MAX_JUMP))
    else $error("window count beyond depth");

  a_issue_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> (issue_cnt_r <= span_r) && (span_r <= lim_eff))
    else $error("read count beyond span");

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FINISH))
    else $error("result raised outside finish");

  a_first_cost_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && span_r == '0) |-> (best_r == '0))
    else $error("sequence start with nonzero cost");

  a_no_pending_at_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH) |-> (!rd_vld_r && !cand_vld_r))
    else $error("finish with compare still pending");
`endif

endmodule
